@@ design/cspan_pkg.sv @@
`default_nettype none

package cspan_pkg;

    // fixed field widths of the column and span transactions
    localparam int COL_FW     = 10;
    localparam int ROW_FW     = 6;
    localparam int SPAN_COL_W = 9;

    typedef struct packed {
        logic load;
        logic rd_top;
        logic rd_bot;
        logic emit;
        logic wr_top;
        logic wr_bot;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic close_top;
        logic close_bot;
        logic open_top;
        logic open_bot;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ design/cspan_ifs.sv @@
`default_nettype none

interface cspan_col_if;
    logic                          valid;
    logic                          ready;
    logic [cspan_pkg::COL_FW-1:0]  column;
    logic                          covered;
    logic [cspan_pkg::ROW_FW-1:0]  top_row;
    logic [cspan_pkg::ROW_FW-1:0]  bottom_row;

    modport source (output valid, column, covered, top_row, bottom_row, input ready);
    modport sink   (input valid, column, covered, top_row, bottom_row, output ready);
endinterface

interface cspan_span_if;
    logic                              valid;
    logic                              ready;
    logic [cspan_pkg::ROW_FW-1:0]      row;
    logic [cspan_pkg::SPAN_COL_W-1:0]  start_col;
    logic [cspan_pkg::SPAN_COL_W-1:0]  end_col;
    logic                              last;

    modport source (output valid, row, start_col, end_col, last, input ready);
    modport sink   (input valid, row, start_col, end_col, last, output ready);
endinterface

`default_nettype wire

@@ design/cspan_datapath.sv @@
`default_nettype none

module cspan_datapath #(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 512
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire cspan_pkg::t_dp_cmd                 i_cmd,
    output cspan_pkg::t_dp_status                   o_status,
    input  wire logic [cspan_pkg::COL_FW-1:0]       i_column,
    input  wire logic                               i_covered,
    input  wire logic [cspan_pkg::ROW_FW-1:0]       i_top_row,
    input  wire logic [cspan_pkg::ROW_FW-1:0]       i_bottom_row,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [cspan_pkg::ROW_FW-1:0]            o_row,
    output logic [cspan_pkg::SPAN_COL_W-1:0]        o_start_col,
    output logic [cspan_pkg::SPAN_COL_W-1:0]        o_end_col,
    output logic                                    o_last
);

    localparam int RW     = $clog2(ROWS + 1);
    localparam int AW     = $clog2(ROWS);
    localparam int ROW_XW = cspan_pkg::ROW_FW + 1;
    localparam int CW     = $clog2(COLUMNS + 1);
    localparam int CMPW   = (CW > cspan_pkg::COL_FW) ? CW : cspan_pkg::COL_FW;
    localparam int SW     = cspan_pkg::SPAN_COL_W;

    // interval walk registers, values 0..ROWS
    logic [RW-1:0] r_t1, n_t1, r_b1, n_b1;
    logic [RW-1:0] r_nt, n_nt, r_nb, n_nb;
    logic [RW-1:0] r_et, n_et, r_eb, n_eb;

    logic [SW-1:0] r_col, n_col, r_end, n_end;
    logic          r_new_cov, n_new_cov;
    logic [AW-1:0] r_new_top, n_new_top, r_new_bot, n_new_bot;
    logic          r_prev_cov, n_prev_cov;
    logic [AW-1:0] r_prev_top, n_prev_top, r_prev_bot, n_prev_bot;
    logic [AW-1:0] r_emit_row, n_emit_row;

    logic [SW-1:0] r_rdata;
    logic [SW-1:0] r_row_start [ROWS];

    logic                           r_out_valid, n_out_valid;
    logic [cspan_pkg::ROW_FW-1:0]   r_out_row, n_out_row;
    logic [SW-1:0]                  r_out_start, n_out_start;
    logic [SW-1:0]                  r_out_end, n_out_end;
    logic                           r_out_last, n_out_last;

    logic [CMPW-1:0]   col_ext, col_sat;
    logic [ROW_XW-1:0] t_ext, b_ext, b_sat;
    logic              cov_ok, cov_adj;

    logic              close_top, close_bot, open_top, open_bot;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;

    // input item clean-up: saturate column and bottom row, drop empty or out-of-range intervals
    always_comb begin
        col_ext = CMPW'(i_column);
        col_sat = (col_ext > CMPW'(COLUMNS)) ? CMPW'(COLUMNS) : col_ext;
        t_ext   = {1'b0, i_top_row};
        b_ext   = {1'b0, i_bottom_row};
        b_sat   = (b_ext >= ROW_XW'(ROWS)) ? ROW_XW'(ROWS - 1) : b_ext;
        cov_ok  = i_covered && (t_ext < ROW_XW'(ROWS));
        cov_adj = cov_ok && (t_ext <= b_sat);
    end

    assign close_top = (r_t1 < r_nt) && (r_t1 <= r_b1);
    assign close_bot = (r_b1 > r_nb) && (r_b1 >= r_t1);
    assign open_top  = (r_et < r_t1) && (r_et <= r_eb);
    assign open_bot  = (r_eb > r_b1) && (r_eb >= r_et);

    assign rd_en   = i_cmd.rd_top | i_cmd.rd_bot;
    assign rd_addr = i_cmd.rd_top ? AW'(r_t1) : AW'(r_b1);
    assign wr_en   = i_cmd.wr_top | i_cmd.wr_bot;
    assign wr_addr = i_cmd.wr_top ? AW'(r_et) : AW'(r_eb);

    always_comb begin
        o_status.close_top = close_top;
        o_status.close_bot = close_bot;
        o_status.open_top  = open_top;
        o_status.open_bot  = open_bot;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_t1        = r_t1;
        n_b1        = r_b1;
        n_nt        = r_nt;
        n_nb        = r_nb;
        n_et        = r_et;
        n_eb        = r_eb;
        n_col       = r_col;
        n_end       = r_end;
        n_new_cov   = r_new_cov;
        n_new_top   = r_new_top;
        n_new_bot   = r_new_bot;
        n_prev_cov  = r_prev_cov;
        n_prev_top  = r_prev_top;
        n_prev_bot  = r_prev_bot;
        n_emit_row  = r_emit_row;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_start = r_out_start;
        n_out_end   = r_out_end;
        n_out_last  = r_out_last;

        if (i_cmd.load) begin
            // an empty interval sits past every row: top ROWS, bottom 0
            n_t1      = r_prev_cov ? RW'(r_prev_top) : RW'(ROWS);
            n_b1      = r_prev_cov ? RW'(r_prev_bot) : '0;
            n_nt      = cov_adj ? RW'(t_ext) : RW'(ROWS);
            n_nb      = cov_adj ? RW'(b_sat) : '0;
            n_et      = cov_adj ? RW'(t_ext) : RW'(ROWS);
            n_eb      = cov_adj ? RW'(b_sat) : '0;
            n_col     = col_sat[SW-1:0];
            n_end     = col_sat[SW-1:0] - SW'(1);
            n_new_cov = cov_adj;
            n_new_top = cov_adj ? AW'(t_ext) : '0;
            n_new_bot = cov_adj ? AW'(b_sat) : '0;
        end
        if (i_cmd.rd_top) begin
            n_emit_row = rd_addr;
            n_t1       = r_t1 + RW'(1);
        end
        if (i_cmd.rd_bot) begin
            n_emit_row = rd_addr;
            n_b1       = r_b1 - RW'(1);
        end
        if (i_cmd.wr_top) begin
            n_et = r_et + RW'(1);
        end
        if (i_cmd.wr_bot) begin
            n_eb = r_eb - RW'(1);
        end
        if (i_cmd.commit) begin
            n_prev_cov = r_new_cov;
            n_prev_top = r_new_top;
            n_prev_bot = r_new_bot;
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_row   = cspan_pkg::ROW_FW'(r_emit_row);
            n_out_start = r_rdata;
            n_out_end   = r_end;
            // walk registers already moved past this row
            n_out_last  = !(close_top || close_bot);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1        <= RW'(ROWS);
            r_b1        <= '0;
            r_et        <= RW'(ROWS);
            r_eb        <= '0;
            r_prev_cov  <= 1'b0;
            r_prev_top  <= '0;
            r_prev_bot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_t1        <= n_t1;
            r_b1        <= n_b1;
            r_et        <= n_et;
            r_eb        <= n_eb;
            r_prev_cov  <= n_prev_cov;
            r_prev_top  <= n_prev_top;
            r_prev_bot  <= n_prev_bot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nt        <= n_nt;
        r_nb        <= n_nb;
        r_col       <= n_col;
        r_end       <= n_end;
        r_new_cov   <= n_new_cov;
        r_new_top   <= n_new_top;
        r_new_bot   <= n_new_bot;
        r_emit_row  <= n_emit_row;
        r_out_row   <= n_out_row;
        r_out_start <= n_out_start;
        r_out_end   <= n_out_end;
        r_out_last  <= n_out_last;
    end

    // start column store, one write or one registered read per cycle, never both
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_row_start[wr_addr] <= r_col;
        end
        if (rd_en) begin
            r_rdata <= r_row_start[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row       = r_out_row;
    assign o_start_col = r_out_start;
    assign o_end_col   = r_out_end;
    assign o_last      = r_out_last;

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (RW'(rd_addr) < RW'(ROWS)))
        else $error("start column read outside the row range");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (RW'(wr_addr) < RW'(ROWS)))
        else $error("start column write outside the row range");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("read and write of the start store in one cycle");

endmodule

`default_nettype wire

@@ design/cspan_ctrl.sv @@
`default_nettype none

module cspan_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire cspan_pkg::t_dp_status  i_status,
    output cspan_pkg::t_dp_cmd          o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_OPEN  = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rows above the new interval close before rows below it
                priority if (i_status.close_top) begin
                    o_cmd.rd_top = 1'b1;
                    n_state      = ST_FETCH;
                end else if (i_status.close_bot) begin
                    o_cmd.rd_bot = 1'b1;
                    n_state      = ST_FETCH;
                end else begin
                    n_state = ST_OPEN;
                end
            end
            ST_FETCH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_OPEN: begin
                priority if (i_status.open_top) begin
                    o_cmd.wr_top = 1'b1;
                end else if (i_status.open_bot) begin
                    o_cmd.wr_bot = 1'b1;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_idle_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(i_status.close_top || i_status.close_bot ||
                                   i_status.open_top || i_status.open_bot))
        else $error("idle with rows still to close or open");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("span loaded over a waiting span");

    a_read_then_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd_top || o_cmd.rd_bot) |=> (r_state == ST_FETCH))
        else $error("start column read not followed by fetch");

endmodule

`default_nettype wire

@@ design/column_to_span_converter.sv @@
`default_nettype none

// channel   dir   transaction
// i_col     in    one screen column: column, covered, top_row, bottom_row
// o_span    out   one finished span: row, start_col, end_col, last
//
// a column is accepted in the idle step; each span it closes takes a start column
// read from the single-port row store, then a load of the output register; each
// row it opens takes one store write, and the walk then finishes with a commit.
// synchronous active-low reset; the row start store is not cleared.
// a stalled o_span holds the walk in its fetch step; a waiting span does not
// block acceptance of the next column.

module column_to_span_converter #(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 512
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cspan_col_if.sink   i_col,
    cspan_span_if.source o_span
);

    cspan_pkg::t_dp_cmd    cmd;
    cspan_pkg::t_dp_status status;
    logic                  in_ready;

    cspan_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_col.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cspan_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_column     (i_col.column),
        .i_covered    (i_col.covered),
        .i_top_row    (i_col.top_row),
        .i_bottom_row (i_col.bottom_row),
        .i_out_ready  (o_span.ready),
        .o_out_valid  (o_span.valid),
        .o_row        (o_span.row),
        .o_start_col  (o_span.start_col),
        .o_end_col    (o_span.end_col),
        .o_last       (o_span.last)
    );

    assign i_col.ready = in_ready;

endmodule

`default_nettype wire
